// ===== hdl/bbss_pkg.sv =====
// ----------------------------------------------------------------------------
// Biphasic burst stimulation sequencer: shared definitions
// Register map, reset values, drive command codes and the configuration
// bundle that travels from the register file to the sequencer.
// ----------------------------------------------------------------------------
package bbss_pkg;

    // Width of the window and phase counters.
    localparam int CNT_BITS_DEF = 24;

    // Field widths.
    localparam int TICKS_W = 24;
    localparam int COUNT_W = 8;

    // Register file port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register reset values.
    localparam logic [TICKS_W-1:0] BURST_ON_RST   = 24'd366412;
    localparam logic [TICKS_W-1:0] BURST_REST_RST = 24'd3664122;
    localparam logic [TICKS_W-1:0] PULSE_ON_RST   = 24'd6;
    localparam logic [TICKS_W-1:0] PULSE_GAP_RST  = 24'd604;
    localparam logic [COUNT_W-1:0] TARGET_RST     = 8'd5;

    // Register indexes (word address).
    typedef enum logic [REG_IDX_W-1:0] {
        REG_BURST_ON   = 3'd0,
        REG_BURST_REST = 3'd1,
        REG_PULSE_ON   = 3'd2,
        REG_PULSE_GAP  = 3'd3,
        REG_TARGET     = 3'd4
    } t_reg_idx;

    // Commands to the current driver.
    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_STOP = 2'd1,
        CMD_POS  = 2'd2,
        CMD_NEG  = 2'd3
    } t_cmd;

    // Configuration bundle.
    typedef struct packed {
        logic [TICKS_W-1:0] burst_on;
        logic [TICKS_W-1:0] burst_rest;
        logic [TICKS_W-1:0] pulse_on;
        logic [TICKS_W-1:0] pulse_gap;
        logic [COUNT_W-1:0] target;
    } t_cfg;

endpackage

// ===== hdl/bbss_regs.sv =====
// ----------------------------------------------------------------------------
// Biphasic burst stimulation sequencer: register file
// APB-style register file holding the window, pulse and burst count settings.
// ----------------------------------------------------------------------------
module bbss_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbss_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    output bbss_pkg::t_cfg                  o_cfg
);
    import bbss_pkg::*;

    t_cfg             r_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.burst_on   <= BURST_ON_RST;
            r_cfg.burst_rest <= BURST_REST_RST;
            r_cfg.pulse_on   <= PULSE_ON_RST;
            r_cfg.pulse_gap  <= PULSE_GAP_RST;
            r_cfg.target     <= TARGET_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_BURST_ON:   r_cfg.burst_on   <= pwdata[TICKS_W-1:0];
                REG_BURST_REST: r_cfg.burst_rest <= pwdata[TICKS_W-1:0];
                REG_PULSE_ON:   r_cfg.pulse_on   <= pwdata[TICKS_W-1:0];
                REG_PULSE_GAP:  r_cfg.pulse_gap  <= pwdata[TICKS_W-1:0];
                REG_TARGET:     r_cfg.target     <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            REG_BURST_ON:   prdata = APB_DATA_W'(r_cfg.burst_on);
            REG_BURST_REST: prdata = APB_DATA_W'(r_cfg.burst_rest);
            REG_PULSE_ON:   prdata = APB_DATA_W'(r_cfg.pulse_on);
            REG_PULSE_GAP:  prdata = APB_DATA_W'(r_cfg.pulse_gap);
            REG_TARGET:     prdata = APB_DATA_W'(r_cfg.target);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/biphasic_burst_stim_sequencer.sv =====
// ----------------------------------------------------------------------------
// Biphasic burst stimulation sequencer
// Steps a burst/rest window and a four-phase biphasic pulse cycle once per
// timer tick and reports the drive command, LED toggle and burst status.
// ----------------------------------------------------------------------------
// Usage:
//   Each word on the s_axis channel is one timer tick carrying the button
//   level in bit 0. For every accepted tick exactly one result word leaves
//   on the m_axis channel with the drive command, the LED toggle flag, the
//   burst count and the armed flag.
//   The result of a tick accepted at one clock edge is shown on m_axis from
//   that edge on. Throughput is one tick per cycle while the receiver takes
//   each result; the sequencer state and the result register are both
//   updated in the cycle that takes the tick.
//   When the receiver stalls, the result stays in the output register and
//   s_axis_tready drops until it is taken; a new tick is accepted in the same
//   cycle that the waiting result leaves.
//   The APB port sets window lengths, pulse lengths and the burst target;
//   write it only while no tick is in flight.
//   Reset (synchronous, active low) restores the default settings, disarms
//   the sequencer and empties the output register.
// ----------------------------------------------------------------------------
module biphasic_burst_stim_sequencer #(
    parameter int COUNTER_BITS = bbss_pkg::CNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Tick input
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] button_level
    // Result output
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [1:0] drive_command, [2] led_toggle, [10:3] bursts_done_now, [11] armed_now
    output logic [15:0]                     m_axis_tdata,
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbss_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbss_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbss_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import bbss_pkg::*;

    // Compare width covers both the counter and the 24-bit lengths.
    localparam int CMP_W = (COUNTER_BITS > TICKS_W) ? COUNTER_BITS : TICKS_W;

    // Phase codes of the four-phase cycle.
    localparam logic [1:0] PH_POS   = 2'd0;
    localparam logic [1:0] PH_STOP1 = 2'd1;
    localparam logic [1:0] PH_NEG   = 2'd2;

    t_cfg w_cfg;

    // Sequencer state.
    logic                    r_armed,     n_armed;
    logic [COUNT_W-1:0]      r_bursts,    n_bursts;
    logic [COUNTER_BITS-1:0] r_win_cnt,   n_win_cnt;
    logic [COUNTER_BITS-1:0] r_ph_cnt,    n_ph_cnt;
    logic                    r_in_burst,  n_in_burst;
    logic [1:0]              r_phase,     n_phase;
    logic                    r_ph_flag,   n_ph_flag;
    logic                    r_stop_sent, n_stop_sent;

    // Output register.
    logic                    r_out_valid;
    logic [15:0]             r_out_data;

    logic                    w_take;
    logic                    w_button;
    logic                    w_run;
    logic                    w_win_end;
    logic                    w_ph_end;
    logic [TICKS_W-1:0]      w_win_len;
    logic [TICKS_W-1:0]      w_ph_len;
    t_cmd                    w_cmd;
    logic                    w_led;

    bbss_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_take        = s_axis_tvalid && s_axis_tready;
    assign w_button      = s_axis_tdata[0];

    // Running means armed with bursts still to go.
    assign w_run     = r_armed && (r_bursts < w_cfg.target);
    assign w_win_len = r_in_burst ? w_cfg.burst_on : w_cfg.burst_rest;
    assign w_ph_len  = r_ph_flag ? w_cfg.pulse_on : w_cfg.pulse_gap;
    assign w_win_end = CMP_W'(r_win_cnt) >= CMP_W'(w_win_len);
    assign w_ph_end  = CMP_W'(r_ph_cnt) >= CMP_W'(w_ph_len);

    // Next state and result for one tick.
    always_comb begin
        n_armed     = r_armed;
        n_bursts    = r_bursts;
        n_win_cnt   = r_win_cnt;
        n_ph_cnt    = r_ph_cnt;
        n_in_burst  = r_in_burst;
        n_phase     = r_phase;
        n_ph_flag   = r_ph_flag;
        n_stop_sent = r_stop_sent;
        w_cmd       = CMD_NONE;
        w_led       = 1'b0;

        if (!w_run) begin
            // Idle or finished: follow the button and clear the count.
            n_armed  = w_button;
            n_bursts = '0;
        end else begin
            // Burst/rest window.
            if (w_win_end) begin
                n_in_burst = !r_in_burst;
                n_win_cnt  = COUNTER_BITS'(1);
                if (!r_in_burst) begin
                    n_bursts = r_bursts + COUNT_W'(1);
                end else if (!r_stop_sent) begin
                    w_cmd       = CMD_STOP;
                    n_stop_sent = 1'b1;
                end
            end else begin
                n_win_cnt = r_win_cnt + COUNTER_BITS'(1);
            end

            // Pulse phases inside a stimulation window.
            if (n_in_burst) begin
                n_stop_sent = 1'b0;
                if (w_ph_end) begin
                    n_ph_cnt = COUNTER_BITS'(1);
                    case (r_phase)
                        PH_POS: begin
                            w_cmd     = CMD_POS;
                            n_ph_flag = 1'b1;
                        end
                        PH_STOP1: begin
                            w_cmd     = CMD_STOP;
                            n_ph_flag = 1'b0;
                        end
                        PH_NEG: begin
                            w_cmd     = CMD_NEG;
                            n_ph_flag = 1'b1;
                        end
                        default: begin
                            w_cmd     = CMD_STOP;
                            n_ph_flag = 1'b0;
                        end
                    endcase
                    n_phase = r_phase + 2'd1;
                    w_led   = 1'b1;
                end else begin
                    n_ph_cnt = r_ph_cnt + COUNTER_BITS'(1);
                end
            end
        end
    end

    // State update on each accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_bursts    <= '0;
            r_win_cnt   <= '0;
            r_ph_cnt    <= '0;
            r_in_burst  <= 1'b1;
            r_phase     <= PH_POS;
            r_ph_flag   <= 1'b1;
            r_stop_sent <= 1'b0;
        end else if (w_take) begin
            r_armed     <= n_armed;
            r_bursts    <= n_bursts;
            r_win_cnt   <= n_win_cnt;
            r_ph_cnt    <= n_ph_cnt;
            r_in_burst  <= n_in_burst;
            r_phase     <= n_phase;
            r_ph_flag   <= n_ph_flag;
            r_stop_sent <= n_stop_sent;
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out_data <= {4'd0, n_armed, n_bursts, w_led, w_cmd};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// ===== hdl/bbss_checker.sv =====
// ----------------------------------------------------------------------------
// Biphasic burst stimulation sequencer: port checker
// Watches the stream and result fields of the top level over time.
// ----------------------------------------------------------------------------
module bbss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);
    import bbss_pkg::*;

    // A stalled result keeps its word.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present after reset");

    // An empty output register never holds off the tick input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // An LED toggle always comes with a drive command.
    a_led_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] != CMD_NONE)
        else $error("LED toggle without command");

    // A disarmed sequencer reports no bursts.
    a_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[11] |-> m_axis_tdata[10:3] == 8'd0)
        else $error("burst count while disarmed");

endmodule

bind biphasic_burst_stim_sequencer bbss_checker u_bbss_checker (.*);
